/* hw/rtl/skht_pkg.sv */
// Package: shared types and codes of the chained hash table
`timescale 1ns / 1ps
package skht_pkg;
  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_FIND   = 2'd1,
    CMD_REMOVE = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NOTFOUND = 2'd1,
    ST_FULL     = 2'd2
  } status_e;

  localparam logic [31:0] HashMul = 32'd31;

  typedef enum logic [3:0] {
    S_COLLECT, S_MOD, S_HEAD, S_ALLOC, S_WRITE, S_FETCH, S_CMPWAIT, S_CMP,
    S_UNLINK, S_RESULT
  } state_e;

  typedef struct packed {
    logic key_take;
    logic mod_start;
    logic head_read;
    logic alloc;
    logic ins_write;
    logic fetch;
    logic cmp_start;
    logic cmp_step;
    logic advance;
    logic unlink;
    logic res_load;
  } cmd_t;

  typedef struct packed {
    logic mod_done;
    logic copy_done;
    logic pool_full;
    logic chain_end;
    logic cmp_done;
    logic cmp_match;
  } sts_t;
endpackage

/* hw/rtl/skht_if.sv */
// Interfaces: input item and result item channels
`timescale 1ns / 1ps
interface skht_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  command;
  logic [7:0]  key_char;
  logic        key_last;
  logic [63:0] record_no;
  modport source(output valid, command, key_char, key_last, record_no, input ready);
  modport sink(input valid, command, key_char, key_last, record_no, output ready);
endinterface

interface skht_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [63:0] found_record;
  modport source(output valid, status, found_record, input ready);
  modport sink(input valid, status, found_record, output ready);
endinterface

/* hw/rtl/skht_ctrl.sv */
// Controller: sequences key collection, hashing, chain walk and updates
`timescale 1ns / 1ps
module skht_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic             in_last_i,
  input  logic [1:0]       in_cmd_i,
  input  logic             out_busy_i,
  output logic             in_ready_o,
  output skht_pkg::cmd_t   cmd_o,
  input  skht_pkg::sts_t   sts_i
);
  import skht_pkg::*;

  state_e state_q, state_d;
  logic [1:0] op_q, op_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_COLLECT;
      op_q    <= 2'd0;
    end else begin
      state_q <= state_d;
      op_q    <= op_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    op_d       = op_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_COLLECT: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.key_take = 1'b1;
          if (in_last_i) begin
            op_d    = in_cmd_i;
            state_d = S_MOD;
          end
        end
      end
      S_MOD: begin
        cmd_o.mod_start = 1'b1;
        if (sts_i.mod_done) state_d = S_HEAD;
      end
      S_HEAD: begin
        cmd_o.head_read = 1'b1;
        if (op_q == CMD_INSERT) state_d = S_ALLOC;
        else if (op_q == CMD_FIND || op_q == CMD_REMOVE) state_d = S_FETCH;
        else state_d = S_RESULT;
      end
      S_ALLOC: begin
        if (sts_i.pool_full) state_d = S_RESULT;
        else begin
          cmd_o.alloc = 1'b1;
          state_d = S_WRITE;
        end
      end
      S_WRITE: begin
        if (sts_i.copy_done) begin
          cmd_o.ins_write = 1'b1;
          state_d = S_RESULT;
        end
      end
      S_FETCH: begin
        if (sts_i.chain_end) state_d = S_RESULT;
        else begin
          cmd_o.fetch = 1'b1;
          state_d = S_CMPWAIT;
        end
      end
      S_CMPWAIT: begin
        cmd_o.cmp_start = 1'b1;
        state_d = S_CMP;
      end
      S_CMP: begin
        cmd_o.cmp_step = 1'b1;
        if (sts_i.cmp_done) begin
          if (sts_i.cmp_match) state_d = (op_q == CMD_REMOVE) ? S_UNLINK : S_RESULT;
          else begin
            cmd_o.advance = 1'b1;
            state_d = S_FETCH;
          end
        end
      end
      S_UNLINK: begin
        cmd_o.unlink = 1'b1;
        state_d = S_RESULT;
      end
      S_RESULT: begin
        if (!out_busy_i) begin
          cmd_o.res_load = 1'b1;
          state_d = S_COLLECT;
        end
      end
      default: state_d = S_COLLECT;
    endcase
  end
endmodule

/* hw/rtl/skht_dp.sv */
// Datapath: key buffer, hash, modulo, node memories and result register
`timescale 1ns / 1ps
module skht_dp #(
  parameter int NAME_BYTES  = 32,
  parameter int POOL_NODES  = 256,
  parameter int MAX_BUCKETS = 64
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  skht_pkg::cmd_t   cmd_i,
  output skht_pkg::sts_t   sts_o,
  input  logic [1:0]       in_cmd_i,
  input  logic [7:0]       key_char_i,
  input  logic [63:0]      record_no_i,
  input  logic             cfg_we_i,
  input  logic [6:0]       cfg_wdata_i,
  output logic             out_busy_o,
  skht_out_if.source       out_if
);
  import skht_pkg::*;

  localparam int KW  = $clog2(NAME_BYTES);
  localparam int LW  = $clog2(NAME_BYTES + 1);
  localparam int NW  = $clog2(POOL_NODES + 1);
  localparam int IW  = (POOL_NODES > 1) ? $clog2(POOL_NODES) : 1;
  localparam int BW  = (MAX_BUCKETS > 1) ? $clog2(MAX_BUCKETS) : 1;
  localparam int BCW = $clog2(MAX_BUCKETS + 1);
  localparam logic [NW-1:0] NoNode = NW'(POOL_NODES);

  // configuration
  logic [6:0] bcount_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) bcount_q <= 7'd64;
    else if (cfg_we_i) bcount_q <= cfg_wdata_i;
  end
  logic [BCW-1:0] buckets;
  always_comb begin
    if (bcount_q == 7'd0) buckets = BCW'(1);
    else if (32'(bcount_q) > 32'(MAX_BUCKETS)) buckets = BCW'(MAX_BUCKETS);
    else buckets = BCW'(bcount_q);
  end

  // key collection
  logic [7:0]    kbuf_q [NAME_BYTES];
  logic [LW-1:0] klen_q;
  logic          kover_q, kend_q;
  logic [31:0]   hash_q;
  logic [1:0]    op_q;
  logic [63:0]   rec_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      klen_q  <= '0;
      kover_q <= 1'b0;
      kend_q  <= 1'b0;
      hash_q  <= '0;
    end else if (cmd_i.res_load) begin
      klen_q  <= '0;
      kover_q <= 1'b0;
      kend_q  <= 1'b0;
      hash_q  <= '0;
    end else if (cmd_i.key_take && !kend_q) begin
      if (key_char_i == 8'd0) kend_q <= 1'b1;
      else begin
        hash_q <= hash_q * HashMul + 32'(key_char_i);
        if (32'(klen_q) < 32'(NAME_BYTES - 1)) klen_q <= klen_q + LW'(1);
        else kover_q <= 1'b1;
      end
    end
  end
  always_ff @(posedge clk_i) begin
    if (cmd_i.key_take) begin
      op_q  <= in_cmd_i;
      rec_q <= record_no_i;
      if (!kend_q && key_char_i != 8'd0 && 32'(klen_q) < 32'(NAME_BYTES - 1))
        kbuf_q[klen_q[KW-1:0]] <= key_char_i;
    end
  end

  // restoring modulo, one quotient bit per cycle
  logic [31:0]  rem_q;
  logic [5:0]   mstep_q;
  logic         mbusy_q;
  logic [32:0]  mtry;
  logic [BW-1:0] bucket;
  assign mtry = {1'b0, rem_q} - ({1'b0, 32'(buckets)} << (6'd31 - mstep_q));
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mbusy_q <= 1'b0;
      mstep_q <= '0;
    end else if (cmd_i.mod_start) begin
      if (!mbusy_q) begin
        mbusy_q <= 1'b1;
        mstep_q <= '0;
      end else if (mstep_q == 6'd32) mbusy_q <= 1'b0;
      else mstep_q <= mstep_q + 6'd1;
    end
  end
  always_ff @(posedge clk_i) begin
    if (cmd_i.mod_start && !mbusy_q) rem_q <= hash_q;
    else if (mbusy_q && mstep_q < 6'd32 && !mtry[32] &&
             (({32'd0, 32'(buckets)} << (6'd31 - mstep_q)) >> 32) == 64'd0)
      rem_q <= mtry[31:0];
  end
  assign sts_o.mod_done = mbusy_q && mstep_q == 6'd32;
  assign bucket = BW'(rem_q);

  // bucket heads with valid bits
  logic [NW-1:0] heads_q [MAX_BUCKETS];
  logic [NW-1:0] hrd_q;
  logic [MAX_BUCKETS-1:0] hval_q;
  logic [BW-1:0]  b_q;
  logic [NW-1:0]  cur_q, prev_q, head_rd;
  assign head_rd = hval_q[bucket] ? hrd_q : NoNode;

  // free list
  logic [IW-1:0] fstack_q [POOL_NODES];
  logic [NW-1:0] ftop_q, fresh_q, newn_q;
  logic [IW-1:0] ftop_rd;
  always_ff @(posedge clk_i) ftop_rd <= fstack_q[IW'(ftop_q - NW'(1))];
  assign sts_o.pool_full = (ftop_q == '0) && (fresh_q == NoNode);

  // node memories
  logic [7:0]    nkey_q  [POOL_NODES * NAME_BYTES];
  logic [LW-1:0] nlen_q  [POOL_NODES];
  logic [63:0]   nrec_q  [POOL_NODES];
  logic [NW-1:0] nlink_q [POOL_NODES];
  logic [LW-1:0] len_rd;
  logic [63:0]   rec_rd;
  logic [NW-1:0] link_rd;
  logic [7:0]    nkey_rd;
  logic [LW-1:0] cidx_q;
  logic          cok_q;
  localparam int AW = $clog2(POOL_NODES * NAME_BYTES);
  logic [AW-1:0] waddr, raddr;
  logic [LW-1:0] wcnt_q;
  logic          wbusy_q;

  assign raddr = AW'(32'(cur_q[IW-1:0]) * NAME_BYTES + 32'(cidx_q[KW-1:0]));
  assign waddr = AW'(32'(newn_q[IW-1:0]) * NAME_BYTES + 32'(wcnt_q[KW-1:0]));

  always_ff @(posedge clk_i) begin
    hrd_q <= heads_q[bucket];
    if (cmd_i.ins_write) heads_q[b_q] <= newn_q;
    else if (cmd_i.unlink && prev_q == NoNode) heads_q[b_q] <= link_rd;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.fetch) begin
      len_rd  <= nlen_q[cur_q[IW-1:0]];
      rec_rd  <= nrec_q[cur_q[IW-1:0]];
      link_rd <= nlink_q[cur_q[IW-1:0]];
    end
    nkey_rd <= nkey_q[raddr];
    if (wbusy_q) nkey_q[waddr] <= kbuf_q[wcnt_q[KW-1:0]];
    if (cmd_i.ins_write) begin
      nlen_q[newn_q[IW-1:0]]  <= klen_q;
      nrec_q[newn_q[IW-1:0]]  <= rec_q;
      nlink_q[newn_q[IW-1:0]] <= cur_q;
    end else if (cmd_i.unlink && prev_q != NoNode) begin
      nlink_q[prev_q[IW-1:0]] <= link_rd;
    end
    if (cmd_i.unlink) fstack_q[ftop_q[IW-1:0]] <= cur_q[IW-1:0];
  end

  // key compare: byte by byte against the buffered key, an address phase then a compare phase per byte
  logic cmp_done;
  assign cmp_done = wbusy_q ? 1'b0 :
                    (kover_q || len_rd != klen_q || !cok_q || cidx_q >= klen_q);
  assign sts_o.cmp_done  = cmd_i.cmp_step && cmp_done;
  assign sts_o.cmp_match = !kover_q && len_rd == klen_q && cok_q;
  assign sts_o.chain_end = (cur_q == NoNode);
  assign sts_o.copy_done = !wbusy_q;

  logic cmp_ph_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hval_q  <= '0;
      ftop_q  <= '0;
      fresh_q <= '0;
      wbusy_q <= 1'b0;
      wcnt_q  <= '0;
      cok_q   <= 1'b0;
      cidx_q  <= '0;
      cmp_ph_q <= 1'b0;
      b_q     <= '0;
      cur_q   <= NoNode;
      prev_q  <= NoNode;
      newn_q  <= NoNode;
    end else begin
      if (cmd_i.head_read) begin
        b_q    <= bucket;
        cur_q  <= head_rd;
        prev_q <= NoNode;
        newn_q <= NoNode;
      end
      if (cmd_i.alloc) begin
        if (ftop_q != '0) begin
          ftop_q <= ftop_q - NW'(1);
          newn_q <= NW'(ftop_rd);
        end else begin
          fresh_q <= fresh_q + NW'(1);
          newn_q  <= fresh_q;
        end
        wbusy_q <= 1'b1;
        wcnt_q  <= '0;
      end else if (wbusy_q) begin
        if (wcnt_q + LW'(1) >= klen_q) wbusy_q <= 1'b0;
        wcnt_q <= wcnt_q + LW'(1);
      end
      if (wbusy_q && klen_q == '0) wbusy_q <= 1'b0;
      if (cmd_i.ins_write) hval_q[b_q] <= 1'b1;
      if (cmd_i.cmp_start) begin
        cok_q    <= 1'b1;
        cidx_q   <= '0;
        cmp_ph_q <= 1'b0;
      end else if (cmd_i.cmp_step && !cmp_done) begin
        // alternate: address phase then compare phase (registered read)
        cmp_ph_q <= !cmp_ph_q;
        if (cmp_ph_q) begin
          if (nkey_rd != kbuf_q[cidx_q[KW-1:0]]) cok_q <= 1'b0;
          cidx_q <= cidx_q + LW'(1);
        end
      end
      if (cmd_i.advance) begin
        prev_q <= cur_q;
        cur_q  <= link_rd;
      end
      if (cmd_i.unlink) begin
        if (prev_q == NoNode) hval_q[b_q] <= 1'b1;
        if (32'(ftop_q) < POOL_NODES) ftop_q <= ftop_q + NW'(1);
      end
    end
  end

  // result register
  logic        ov_q;
  logic [1:0]  ost_q;
  logic [63:0] orec_q;
  logic        hit;
  assign hit = (op_q == CMD_FIND || op_q == CMD_REMOVE) && cur_q != NoNode;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) ov_q <= 1'b0;
    else if (cmd_i.res_load) ov_q <= 1'b1;
    else if (out_if.ready) ov_q <= 1'b0;
  end
  always_ff @(posedge clk_i) begin
    if (cmd_i.res_load) begin
      if (op_q == CMD_INSERT) begin
        ost_q  <= (newn_q == NoNode) ? ST_FULL : ST_OK;
        orec_q <= '0;
      end else if (hit) begin
        ost_q  <= ST_OK;
        orec_q <= rec_rd;
      end else begin
        ost_q  <= ST_NOTFOUND;
        orec_q <= '0;
      end
    end
  end
  assign out_busy_o          = ov_q && !out_if.ready;
  assign out_if.valid        = ov_q;
  assign out_if.status       = ost_q;
  assign out_if.found_record = orec_q;
endmodule

/* hw/rtl/string_key_chained_hash_table.sv */
// Top level: chained hash table keyed by byte strings
`timescale 1ns / 1ps
// Channel  Dir  Carries
// in_if    in   command, key_char, key_last, record_no
// out_if   out  status, found_record
// cfg      in   number of buckets in use
// Key bytes: one item per cycle while collecting. Last item: modulo, then head read.
// Insert: alloc (straight to the result if the pool is full), key copy, then link.
// Find/remove: per chain node a chain-end check, fetch, compare start and compare
// (byte walk when lengths agree); a remove match unlinks. Then the result loads.
// Reset empties chains and pool counters at once; a held result stalls the next.
module string_key_chained_hash_table #(
  parameter int NAME_BYTES  = 32,
  parameter int POOL_NODES  = 256,
  parameter int MAX_BUCKETS = 64
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  skht_in_if.sink    in_if,
  skht_out_if.source out_if,
  input  logic       cfg_we_i,
  input  logic [6:0] cfg_wdata_i
);
  import skht_pkg::*;

  cmd_t cmd;
  sts_t sts;
  logic busy;

  skht_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i (in_if.valid),
    .in_last_i  (in_if.key_last),
    .in_cmd_i   (in_if.command),
    .out_busy_i (busy),
    .in_ready_o (in_if.ready),
    .cmd_o      (cmd),
    .sts_i      (sts)
  );

  skht_dp #(
    .NAME_BYTES(NAME_BYTES), .POOL_NODES(POOL_NODES), .MAX_BUCKETS(MAX_BUCKETS)
  ) u_dp (
    .clk_i, .rst_ni,
    .cmd_i          (cmd),
    .sts_o          (sts),
    .in_cmd_i       (in_if.command),
    .key_char_i     (in_if.key_char),
    .record_no_i    (in_if.record_no),
    .cfg_we_i, .cfg_wdata_i,
    .out_busy_o     (busy),
    .out_if         (out_if)
  );
endmodule
